/* hw/rtl/cpr_pkg.sv */
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants, types and codes of the clock page replacement unit.
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int MAX_FRAMES  = 16;
    localparam int PAGE_BITS   = 16;
    localparam int CFG_W       = 5;
    localparam int FRAME_IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W       = $clog2(MAX_FRAMES + 1);
    localparam int FAULT_W     = 16;
    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(4);

    typedef enum logic [1:0] {
        OUT_HIT     = 2'd0,
        OUT_FILL    = 2'd1,
        OUT_REPLACE = 2'd2
    } outcome_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // command broadcast to every cell
    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic                 do_hit;
        logic                 do_fill;
        logic                 do_replace;
        logic                 all_set;
    } cell_cmd_t;

    // where a cell stands relative to the hand and the frame count
    typedef struct packed {
        logic active;
        logic is_start;
        logic in_lo;
    } cell_pos_t;

    // signals handed from one cell to the next
    typedef struct packed {
        logic hit;
        logic free;
        logic seek_hi;
        logic seek_lo;
    } cell_chain_t;

endpackage

/* hw/rtl/cpr_cell.sv */
// ----------------------------------------------------------------------------
// cpr_cell
// One page frame: page number, valid mark and use bit, with the compare,
// free-frame and second-chance sweep logic that ripples along the row.
// ----------------------------------------------------------------------------
module cpr_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 commit,
    input  cpr_pkg::cell_cmd_t   cmd,
    input  cpr_pkg::cell_pos_t   pos,
    input  cpr_pkg::cell_chain_t chain_in,
    output cpr_pkg::cell_chain_t chain_out,
    output logic                 victim
);

    logic [cpr_pkg::PAGE_BITS-1:0] page_reg;
    logic                          valid_reg;
    logic                          use_reg;
    logic                          valid_next;
    logic                          use_next;
    logic                          load_page;

    logic my_hit;
    logic my_free;
    logic arrive_hi;
    logic arrive_lo;
    logic act_hi;
    logic clr;
    logic vic_hi;
    logic vic_lo;

    always_comb
    begin
        my_hit    = pos.active && valid_reg && (page_reg == cmd.page);
        my_free   = pos.active && !valid_reg;
        arrive_hi = pos.is_start || chain_in.seek_hi;
        act_hi    = pos.active && arrive_hi;
        arrive_lo = pos.in_lo && chain_in.seek_lo;
        vic_hi    = act_hi && !use_reg;
        vic_lo    = arrive_lo && !use_reg;
        clr       = (act_hi || arrive_lo) && use_reg;

        chain_out.hit     = chain_in.hit || my_hit;
        chain_out.free    = chain_in.free || my_free;
        chain_out.seek_hi = pos.active ? (act_hi && use_reg) : chain_in.seek_hi;
        chain_out.seek_lo = pos.in_lo ? (arrive_lo && use_reg) : chain_in.seek_lo;

        victim = vic_hi || vic_lo || (cmd.all_set && pos.is_start);
    end

    always_comb
    begin
        valid_next = valid_reg;
        use_next   = use_reg;
        load_page  = 1'b0;
        if (commit)
        begin
            if (cmd.do_hit && my_hit && !chain_in.hit)
            begin
                use_next = 1'b1;
            end
            else if (cmd.do_fill && my_free && !chain_in.free)
            begin
                valid_next = 1'b1;
                use_next   = 1'b1;
                load_page  = 1'b1;
            end
            else if (cmd.do_replace)
            begin
                if (victim)
                begin
                    use_next  = 1'b1;
                    load_page = 1'b1;
                end
                else if (clr)
                begin
                    use_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            use_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            use_reg   <= use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_page)
        begin
            page_reg <= cmd.page;
        end
    end

endmodule

/* hw/rtl/clock_page_replacement_unit.sv */
// ----------------------------------------------------------------------------
// clock_page_replacement_unit
// Clock (second-chance) page replacement over a row of frame cells.
// ----------------------------------------------------------------------------
// Each page reference is taken in the idle state, where its beat is registered;
// in the lookup state the row of frame cells resolves the lookup, the lowest
// free frame or the second-chance sweep from the hand in one ripple along
// the row and commits it, loading the outcome register. The lookup cycle
// waits while an earlier outcome beat is still held unread; the outcome
// register lets a new reference be taken while the last result waits.
// Frame storage needs no clearing pass after reset.
module clock_page_replacement_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [cpr_pkg::PAGE_BITS-1:0]        page,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           outcome,
    input  logic                                 cfg_we,
    input  logic [cpr_pkg::CFG_W-1:0]            cfg_wdata
);

    localparam int N = cpr_pkg::MAX_FRAMES;

    cpr_pkg::state_t                    state_reg, state_next;
    logic [cpr_pkg::PAGE_BITS-1:0]      page_reg;
    logic [cpr_pkg::CFG_W-1:0]          frames_reg;
    logic [cpr_pkg::FRAME_IDX_W-1:0]    hand_reg, hand_next;
    logic [cpr_pkg::FAULT_W-1:0]        fault_reg, fault_next;
    logic                               out_valid_reg, out_valid_next;
    cpr_pkg::outcome_t                  outcome_reg, outcome_next;

    logic [cpr_pkg::CNT_W-1:0]          n_eff;
    logic [cpr_pkg::FRAME_IDX_W-1:0]    hand_eff;
    logic [cpr_pkg::FRAME_IDX_W-1:0]    victim_idx;
    logic [cpr_pkg::FRAME_IDX_W-1:0]    step_from;
    logic [cpr_pkg::CNT_W-1:0]          step_inc;
    logic                               commit;
    logic                               any_hit;
    logic                               any_free;

    cpr_pkg::cell_cmd_t                 cmd;
    cpr_pkg::cell_pos_t                 pos     [N];
    cpr_pkg::cell_chain_t               chain_i [N];
    cpr_pkg::cell_chain_t               chain_o [N];
    logic [N-1:0]                       victim;

    always_comb
    begin
        if (frames_reg == '0)
        begin
            n_eff = cpr_pkg::CNT_W'(1);
        end
        else if (cpr_pkg::CNT_W'(frames_reg) > cpr_pkg::CNT_W'(N))
        begin
            n_eff = cpr_pkg::CNT_W'(N);
        end
        else
        begin
            n_eff = cpr_pkg::CNT_W'(frames_reg);
        end
        hand_eff = ({1'b0, hand_reg} >= n_eff) ? '0 : hand_reg;
    end

    generate
        for (genvar i = 0; i < N; i++)
        begin : g_cell
            assign pos[i].active   = cpr_pkg::CNT_W'(i) < n_eff;
            assign pos[i].is_start = cpr_pkg::FRAME_IDX_W'(i) == hand_eff;
            assign pos[i].in_lo    = cpr_pkg::FRAME_IDX_W'(i) < hand_eff;

            if (i == 0)
            begin : g_head
                assign chain_i[i].hit     = 1'b0;
                assign chain_i[i].free    = 1'b0;
                assign chain_i[i].seek_hi = 1'b0;
                assign chain_i[i].seek_lo = chain_o[N-1].seek_hi;
            end
            else
            begin : g_link
                assign chain_i[i] = chain_o[i-1];
            end

            cpr_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .commit    (commit),
                .cmd       (cmd),
                .pos       (pos[i]),
                .chain_in  (chain_i[i]),
                .chain_out (chain_o[i]),
                .victim    (victim[i])
            );
        end
    endgenerate

    always_comb
    begin
        any_hit        = chain_o[N-1].hit;
        any_free       = chain_o[N-1].free;
        cmd.page       = page_reg;
        cmd.do_hit     = any_hit;
        cmd.do_fill    = !any_hit && any_free;
        cmd.do_replace = !any_hit && !any_free;
        cmd.all_set    = chain_o[N-1].seek_lo;

        victim_idx = '0;
        for (int k = 0; k < N; k++)
        begin
            if (victim[k])
            begin
                victim_idx = victim_idx | cpr_pkg::FRAME_IDX_W'(k);
            end
        end
    end

    // hand steps past the victim on a replace, or past the hand on a fill, wrapping at the frame count
    always_comb
    begin
        step_from = cmd.do_replace ? victim_idx : hand_eff;
        step_inc  = cpr_pkg::CNT_W'(step_from) + cpr_pkg::CNT_W'(1);
    end

    always_comb
    begin
        state_next     = state_reg;
        hand_next      = hand_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg;
        outcome_next   = outcome_reg;
        in_ready       = 1'b0;
        commit         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            cpr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = cpr_pkg::ST_LOOKUP;
                end
            end
            cpr_pkg::ST_LOOKUP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = cpr_pkg::ST_IDLE;
                    if (cmd.do_hit)
                    begin
                        outcome_next = cpr_pkg::OUT_HIT;
                    end
                    else
                    begin
                        hand_next = (step_inc >= n_eff) ? '0
                                  : step_inc[cpr_pkg::FRAME_IDX_W-1:0];
                        if (cmd.do_fill)
                        begin
                            outcome_next = cpr_pkg::OUT_FILL;
                        end
                        else
                        begin
                            outcome_next = cpr_pkg::OUT_REPLACE;
                            if (fault_reg != '1)
                            begin
                                fault_next = fault_reg + cpr_pkg::FAULT_W'(1);
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = cpr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpr_pkg::ST_IDLE;
            frames_reg    <= cpr_pkg::FRAMES_RESET;
            hand_reg      <= '0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
            outcome_reg   <= cpr_pkg::OUT_HIT;
        end
        else
        begin
            state_reg     <= state_next;
            hand_reg      <= hand_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            outcome_reg   <= outcome_next;
            if (cfg_we)
            begin
                frames_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            page_reg <= page;
        end
    end

    assign out_valid = out_valid_reg;
    assign outcome   = outcome_reg;

endmodule

/* hw/rtl/cpr_checker.sv */
// ----------------------------------------------------------------------------
// cpr_checker
// Port-level checks on the clock page replacement unit, bound to the top.
// ----------------------------------------------------------------------------
module cpr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] outcome
);

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result beat during reset");

    // one reference in flight: input closes for the lookup cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second reference taken during lookup");

    // outcome code is hit, fill or replace
    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outcome == cpr_pkg::OUT_HIT || outcome == cpr_pkg::OUT_FILL
                       || outcome == cpr_pkg::OUT_REPLACE))
        else $error("outcome code out of range");

    // held result beat keeps its outcome
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(outcome))
        else $error("result beat dropped or changed while stalled");

endmodule

bind clock_page_replacement_unit cpr_checker u_cpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .outcome   (outcome)
);

/* sim/clock_page_replacement_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_page_replacement_unit_tb
// Self-checking bench for the clock page replacement unit. Page references
// are queued in phases, each under its own frame count, and driven with
// random gaps while the outcome side stalls at random. A local model of the
// frames, use bits and hand predicts every outcome beat, and each beat is
// compared in order against the oldest prediction.
// ----------------------------------------------------------------------------
module clock_page_replacement_unit_tb;

    localparam int STUCK_LIMIT = 5000;
    localparam int POOL_SIZE   = 24;
    localparam int PHASE_ITEMS = 152;
    localparam int NUM_PHASES  = 12;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [cpr_pkg::PAGE_BITS-1:0]  page = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [1:0]                     outcome;
    logic                           cfg_we = 1'b0;
    logic [cpr_pkg::CFG_W-1:0]      cfg_wdata = '0;

    // local copy of the frame table
    logic [cpr_pkg::PAGE_BITS-1:0]  frame_tag [cpr_pkg::MAX_FRAMES];
    bit                             frame_live [cpr_pkg::MAX_FRAMES];
    bit                             second_chance [cpr_pkg::MAX_FRAMES];
    int                             hand_pos;
    int                             fault_tally;
    logic [cpr_pkg::CFG_W-1:0]      frame_count_reg;

    logic [cpr_pkg::PAGE_BITS-1:0]  page_queue [$];
    cpr_pkg::outcome_t              outcome_queue [$];
    int                             pages_queued;
    int                             pages_taken;
    int                             errors;
    int                             stuck_cycles;
    int                             send_gap;
    int                             recv_stall;
    bit                             send_burst;
    bit                             recv_burst;
    bit                             page_taken;

    clock_page_replacement_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .page      (page),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .outcome   (outcome),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int active_frames(input logic [cpr_pkg::CFG_W-1:0] cnt);
        int n;
        n = int'(cnt);
        if (n < 1)
            n = 1;
        if (n > cpr_pkg::MAX_FRAMES)
            n = cpr_pkg::MAX_FRAMES;
        return n;
    endfunction

    function automatic int wrap_next(input int i, input int n);
        return (i + 1 >= n) ? 0 : i + 1;
    endfunction

    function automatic cpr_pkg::outcome_t resolve_reference(
        input logic [cpr_pkg::PAGE_BITS-1:0] pg);
        int n;
        int hand;
        int guard;
        n = active_frames(frame_count_reg);
        for (int i = 0; i < n; i++)
        begin
            if (frame_live[i] && frame_tag[i] == pg)
            begin
                second_chance[i] = 1'b1;
                return cpr_pkg::OUT_HIT;
            end
        end
        hand = (hand_pos >= n) ? 0 : hand_pos;
        for (int i = 0; i < n; i++)
        begin
            if (!frame_live[i])
            begin
                frame_tag[i] = pg;
                frame_live[i] = 1'b1;
                second_chance[i] = 1'b1;
                hand_pos = wrap_next(hand, n);
                return cpr_pkg::OUT_FILL;
            end
        end
        guard = 0;
        while (guard <= n && second_chance[hand])
        begin
            second_chance[hand] = 1'b0;
            hand = wrap_next(hand, n);
            guard++;
        end
        frame_tag[hand] = pg;
        second_chance[hand] = 1'b1;
        hand_pos = wrap_next(hand, n);
        if (fault_tally < 16'hFFFF)
            fault_tally++;
        return cpr_pkg::OUT_REPLACE;
    endfunction

    function automatic int pick_gap(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < 20)
            $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic write_frame_count(input logic [cpr_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        frame_count_reg = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_page(input logic [cpr_pkg::PAGE_BITS-1:0] pg);
        page_queue.push_back(pg);
        pages_queued++;
    endtask

    task automatic wait_drained();
        while (!(pages_taken == pages_queued && outcome_queue.size() == 0))
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || page_taken)
            begin
                page_taken = 1'b0;
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (page_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    page <= page_queue.pop_front();
                    send_gap = pick_gap(send_burst);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // outcome back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // monitor: check outcome beats, predict on accepted page beats
    always @(posedge clk)
    begin
        cpr_pkg::outcome_t exp_outcome;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (outcome_queue.size() == 0)
                begin
                    report_mismatch($sformatf("outcome beat %0d with nothing expected",
                                              outcome));
                end
                else
                begin
                    exp_outcome = outcome_queue.pop_front();
                    if (outcome !== exp_outcome)
                        report_mismatch($sformatf("outcome %0d, expected %0d",
                                                  outcome, exp_outcome));
                end
                recv_stall = pick_gap(recv_burst);
                if ($urandom_range(0, 49) == 0)
                    recv_burst = !recv_burst;
            end
            if (in_valid && in_ready)
            begin
                outcome_queue.push_back(resolve_reference(page));
                pages_taken++;
                page_taken = 1'b1;
                if ($urandom_range(0, 49) == 0)
                    send_burst = !send_burst;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)
            || (pages_taken == pages_queued && outcome_queue.size() == 0))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("clock_page_replacement_unit test failed");
            $finish;
        end
    end

    initial
    begin
        logic [cpr_pkg::CFG_W-1:0]     phase_counts [NUM_PHASES];
        logic [cpr_pkg::PAGE_BITS-1:0] page_pool [POOL_SIZE];
        int                            reach;
        int                            n;

        phase_counts = '{5'd16, 5'd3, 5'd1, 5'd31, 5'd0, 5'd8,
                         5'd17, 5'd5, 5'd16, 5'd2, 5'd12, 5'd16};
        for (int i = 0; i < cpr_pkg::MAX_FRAMES; i++)
        begin
            frame_tag[i] = '0;
            frame_live[i] = 1'b0;
            second_chance[i] = 1'b0;
        end
        hand_pos = 0;
        fault_tally = 0;
        frame_count_reg = cpr_pkg::FRAMES_RESET;
        pages_queued = 0;
        pages_taken = 0;
        errors = 0;
        stuck_cycles = 0;
        send_gap = 0;
        recv_stall = 0;
        send_burst = 1'b0;
        recv_burst = 1'b0;
        page_taken = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
            page_pool[i] = cpr_pkg::PAGE_BITS'($urandom);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // four frames: fill, hit, full sweep and replacement
        write_frame_count(5'd4);
        queue_page(16'h0000);
        queue_page(16'hFFFF);
        queue_page(16'h00FF);
        queue_page(16'hFF00);
        queue_page(16'hFFFF);
        queue_page(16'h0000);
        queue_page(16'h1234);
        queue_page(16'h0000);
        queue_page(16'h1234);
        queue_page(16'hAAAA);
        queue_page(16'h5555);
        wait_drained();

        // shrink: upper frames hidden
        write_frame_count(5'd2);
        queue_page(16'h00FF);
        queue_page(16'hFF00);
        queue_page(16'hAAAA);
        wait_drained();

        // grow again: hidden frames return
        write_frame_count(5'd4);
        queue_page(16'h00FF);
        queue_page(16'hFF00);
        queue_page(16'hAAAA);
        queue_page(16'h5555);
        wait_drained();

        // zero acts as one frame
        write_frame_count(5'd0);
        queue_page(16'h0007);
        queue_page(16'h0007);
        queue_page(16'h0008);
        wait_drained();

        // above the built count acts as all frames
        write_frame_count(5'd31);
        queue_page(16'h0008);
        queue_page(16'h8000);
        queue_page(16'h0001);
        wait_drained();

        for (int p = 0; p < NUM_PHASES + 2; p++)
        begin
            if (p < NUM_PHASES)
                write_frame_count(phase_counts[p]);
            else
                write_frame_count(cpr_pkg::CFG_W'($urandom_range(0, 31)));
            for (int i = 0; i < 6; i++)
                page_pool[$urandom_range(0, POOL_SIZE - 1)] =
                    cpr_pkg::PAGE_BITS'($urandom);
            n = active_frames(frame_count_reg);
            reach = (n + 3 > POOL_SIZE - 1) ? POOL_SIZE - 1 : n + 3;
            for (int i = 0; i < PHASE_ITEMS - 20; i++)
            begin
                if ($urandom_range(0, 99) < 85)
                    queue_page(page_pool[$urandom_range(0, reach)]);
                else
                    queue_page(cpr_pkg::PAGE_BITS'($urandom));
            end
            wait_drained();
        end

        wait_drained();
        if (errors == 0)
            $display("clock_page_replacement_unit test passed");
        else
            $display("clock_page_replacement_unit test failed");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/cpr_pkg.sv
hw/rtl/cpr_cell.sv
hw/rtl/clock_page_replacement_unit.sv
hw/rtl/cpr_checker.sv
sim/clock_page_replacement_unit_tb.sv
